FILE: hw/rtl/smtq_pkg.sv
// Package for the SPI master transaction queue: request/result structs,
// opcodes and slot encoding constants. No dependencies.

package smtq_pkg;

	localparam int BYTE_W = 8;
	localparam int SLOT_CW = 9;

	// Slot counter value meaning "over" (minus one in nine bits)
	localparam logic [SLOT_CW-1:0] SLOT_NONE = 9'h1FF;
	localparam logic [BYTE_W-1:0] FILL_RESET = 8'hFF;

	localparam logic [1:0] OP_QUEUE = 2'd0;
	localparam logic [1:0] OP_PUSH = 2'd1;
	localparam logic [1:0] OP_SHIFT_DONE = 2'd2;
	localparam logic [1:0] OP_POP = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
		logic [7:0] write_count;
		logic [7:0] read_count;
	} req_t;

	typedef struct packed {
		logic       shift_valid;
		logic [7:0] shift_byte;
		logic       pop_valid;
		logic [7:0] pop_byte;
		logic [6:0] rx_level;
		logic [8:0] tx_space;
		logic       slot_ready;
		logic       busy_res;
	} res_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctl_t;

endpackage

FILE: hw/rtl/smtq_fifo.sv
// Byte FIFO with overwrite-on-full: one synchronous memory, pointers, count.
// Depends on smtq_pkg.

module smtq_fifo import smtq_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fifo_ctl_t                    ctl,
	input  logic [BYTE_W-1:0]            wdata,
	output logic [BYTE_W-1:0]            rdata,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [BYTE_W-1:0] rdata_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[wr_ptr_q] <= wdata;
		end
		if (ctl.pop) begin
			rdata_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else if (ctl.push) begin
			wr_ptr_q <= ptr_inc(wr_ptr_q);
			// full: oldest entry is dropped
			if (count_q == CNT_FULL) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end else begin
				count_q <= count_q + 1'b1;
			end
		end else if (ctl.pop) begin
			rd_ptr_q <= ptr_inc(rd_ptr_q);
			count_q <= count_q - 1'b1;
		end
	end

	assign rdata = rdata_q;
	assign count = count_q;

endmodule

FILE: hw/rtl/spi_master_transaction_queue_core.sv
// SPI master transaction queue: slot ring, sequencer FSM and result output.
// Depends on smtq_pkg and smtq_fifo (transmit and receive byte FIFOs).
//
//  channel   signals                      handshake
//  -------   --------------------------   ----------------------------------
//  request   cmd (req_t)                  taken at clk when start && !busy
//  result    result (res_t)               valid for one cycle while done high
//  config    cfg_wdata                    written at clk when cfg_we high
//
// Pop or spurious completion goes EXEC to DONE; queue, push or completion
// also passes SERV, twice when advancing over a finished slot. One request
// at a time; busy is high from accept until done has been shown. The service
// loop runs one slot pass per cycle; a transmit byte comes from the FIFO
// memory in the cycle after its read. Reset is asynchronous and takes effect
// at once; no clearing pass. The receiver cannot stall; done is never held.

module spi_master_transaction_queue_core import smtq_pkg::*; #(
	parameter int TX_DEPTH = 256,
	parameter int RX_DEPTH = 64,
	parameter int SLOT_COUNT = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              cmd,
	output logic              done,
	output res_t              result,
	input  logic              cfg_we,
	input  logic [BYTE_W-1:0] cfg_wdata
);

	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int TXC_W = $clog2(TX_DEPTH+1);
	localparam int RXC_W = $clog2(RX_DEPTH+1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);
	localparam logic [TXC_W-1:0] TX_FULL = TXC_W'(TX_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SERV,
		ST_DONE
	} state_t;

	state_t             state_q;
	req_t               cmd_q;
	logic [BYTE_W-1:0]  fill_q;
	logic [BYTE_W-1:0]  ld_byte_q;
	logic               ld_valid_q;
	logic               ld_tx_q;
	logic               pop_valid_q;
	logic               pass_q;
	logic               shifting_q;
	logic [SLOT_W-1:0]  active_q;
	logic [SLOT_CW-1:0] slot_wl_q [SLOT_COUNT];
	logic [SLOT_CW-1:0] slot_rl_q [SLOT_COUNT];

	fifo_ctl_t          tx_ctl;
	fifo_ctl_t          rx_ctl;
	logic [BYTE_W-1:0]  tx_rdata;
	logic [BYTE_W-1:0]  rx_rdata;
	logic [TXC_W-1:0]   tx_count;
	logic [RXC_W-1:0]   rx_count;
	logic [TXC_W-1:0]   tx_free;

	logic [SLOT_COUNT-1:0] done_vec;
	logic [SLOT_W-1:0]     nxt_slot;
	logic [SLOT_W-1:0]     sel_slot;
	logic [SLOT_W-1:0]     rd_slot;
	logic                  cur_done;
	logic                  serv_idle;
	logic [SLOT_CW-1:0]    wl_rd;
	logic [SLOT_CW-1:0]    rl_rd;
	logic [SLOT_CW-1:0]    rl_dec;
	logic                  wl_pos;
	logic                  rl_pos;
	logic                  tx_emit;
	logic                  capture;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == SLOT_LAST) ? '0 : s + 1'b1;
	endfunction

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			done_vec[i] = (slot_wl_q[i] == SLOT_NONE) && (slot_rl_q[i] == SLOT_NONE);
		end
	end

	always_comb begin
		nxt_slot = slot_inc(active_q);
		cur_done = done_vec[active_q];
		// nothing left to run: current and next slot both finished
		serv_idle = cur_done && done_vec[nxt_slot];
		sel_slot = cur_done ? nxt_slot : active_q;
		rd_slot = (state_q == ST_SERV) ? sel_slot : active_q;
		wl_rd = slot_wl_q[rd_slot];
		rl_rd = slot_rl_q[rd_slot];
		rl_dec = rl_rd - 1'b1;
		wl_pos = (wl_rd != '0) && (wl_rd != SLOT_NONE);
		rl_pos = (rl_rd != '0) && (rl_rd != SLOT_NONE);
		tx_emit = (state_q == ST_SERV) && !shifting_q && !serv_idle && wl_pos
			&& (tx_count != '0);
		capture = (state_q == ST_EXEC) && (cmd_q.opcode == OP_SHIFT_DONE) && shifting_q
			&& (wl_rd == SLOT_NONE) && rl_pos;
	end

	always_comb begin
		tx_ctl.push = (state_q == ST_EXEC) && (cmd_q.opcode == OP_PUSH);
		tx_ctl.pop = tx_emit;
		rx_ctl.push = capture;
		rx_ctl.pop = (state_q == ST_EXEC) && (cmd_q.opcode == OP_POP) && (rx_count != '0);
	end

	smtq_fifo #(
		.DEPTH(TX_DEPTH)
	) u_tx_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (tx_ctl),
		.wdata (cmd_q.data_byte),
		.rdata (tx_rdata),
		.count (tx_count)
	);

	smtq_fifo #(
		.DEPTH(RX_DEPTH)
	) u_rx_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (rx_ctl),
		.wdata (cmd_q.data_byte),
		.rdata (rx_rdata),
		.count (rx_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= FILL_RESET;
		end else if (cfg_we) begin
			fill_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_SERV) begin
			ld_byte_q <= fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ld_valid_q <= 1'b0;
			ld_tx_q <= 1'b0;
			pop_valid_q <= 1'b0;
			pass_q <= 1'b0;
			shifting_q <= 1'b0;
			active_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_wl_q[i] <= SLOT_NONE;
				slot_rl_q[i] <= SLOT_NONE;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						ld_valid_q <= 1'b0;
						ld_tx_q <= 1'b0;
						pop_valid_q <= 1'b0;
						pass_q <= 1'b0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (cmd_q.opcode)
						OP_QUEUE: begin
							// always lands in the slot after the active one
							if (cmd_q.write_count == '0 && cmd_q.read_count == '0) begin
								slot_wl_q[nxt_slot] <= SLOT_NONE;
								slot_rl_q[nxt_slot] <= SLOT_NONE;
							end else begin
								slot_wl_q[nxt_slot] <= {1'b0, cmd_q.write_count};
								slot_rl_q[nxt_slot] <= (cmd_q.read_count == '0) ? SLOT_NONE
									: {1'b0, cmd_q.read_count};
							end
							state_q <= ST_SERV;
						end
						OP_PUSH: begin
							state_q <= ST_SERV;
						end
						OP_SHIFT_DONE: begin
							if (shifting_q) begin
								shifting_q <= 1'b0;
								if (capture) begin
									slot_rl_q[active_q] <= (rl_dec == '0) ? SLOT_NONE : rl_dec;
								end
								state_q <= ST_SERV;
							end else begin
								state_q <= ST_DONE;
							end
						end
						OP_POP: begin
							pop_valid_q <= (rx_count != '0);
							state_q <= ST_DONE;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_SERV: begin
					if (shifting_q || serv_idle) begin
						state_q <= ST_DONE;
					end else begin
						active_q <= sel_slot;
						if (wl_pos) begin
							// data byte due; waits idle if the transmit FIFO is empty
							if (tx_count != '0) begin
								slot_wl_q[sel_slot] <= wl_rd - 1'b1;
								shifting_q <= 1'b1;
								ld_valid_q <= 1'b1;
								ld_tx_q <= 1'b1;
							end
							state_q <= ST_DONE;
						end else begin
							slot_wl_q[sel_slot] <= SLOT_NONE;
							if (rl_pos) begin
								shifting_q <= 1'b1;
								ld_valid_q <= 1'b1;
								state_q <= ST_DONE;
							end else begin
								// slot finished with no load: one more pass may start the next
								slot_rl_q[sel_slot] <= SLOT_NONE;
								pass_q <= 1'b1;
								state_q <= pass_q ? ST_DONE : ST_SERV;
							end
						end
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign tx_free = TX_FULL - tx_count;

	always_comb begin
		result.shift_valid = ld_valid_q;
		result.shift_byte = !ld_valid_q ? '0 : (ld_tx_q ? tx_rdata : ld_byte_q);
		result.pop_valid = pop_valid_q;
		result.pop_byte = pop_valid_q ? rx_rdata : '0;
		result.rx_level = 7'(rx_count);
		result.tx_space = 9'(tx_free);
		result.slot_ready = done_vec[nxt_slot];
		result.busy_res = shifting_q;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule
